[design/affine_gap_alignment_score_assert.svh]
// assertion macros shared by the checker of the alignment score block
`ifndef AFFINE_GAP_ALIGNMENT_SCORE_ASSERT_SVH
`define AFFINE_GAP_ALIGNMENT_SCORE_ASSERT_SVH

// same-cycle implication, off during reset
`define AGAS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("alignment score check failed");

// next-cycle implication, off during reset
`define AGAS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("alignment score check failed");

// next-cycle implication that also holds across reset
`define AGAS_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("alignment score check failed");

`endif

[design/agas_pkg.sv]
// types, constants and score arithmetic of the alignment score block
package agas_pkg;

   localparam int MAX_REF_LEN   = 256;
   localparam int SC_BITS       = 16;
   localparam int IDX_BITS      = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
   localparam int CNT_BITS      = $clog2(MAX_REF_LEN + 1);
   localparam int DELTA_BITS    = 8;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic signed [SC_BITS-1:0]    agas_score_type;
   typedef logic signed [DELTA_BITS-1:0] agas_delta_type;

   localparam agas_score_type SC_MIN = {1'b1, {(SC_BITS-1){1'b0}}};
   localparam agas_score_type SC_MAX = {1'b0, {(SC_BITS-1){1'b1}}};

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] REG_MATCH      = 2'd0;
   localparam logic [1:0] REG_MISMATCH   = 2'd1;
   localparam logic [1:0] REG_GAP_EXTEND = 2'd2;
   localparam logic [1:0] REG_GAP_OPEN   = 2'd3;

   localparam logic signed [4:0] MATCH_RESET      = 5'sd2;
   localparam logic signed [4:0] MISMATCH_RESET   = -5'sd3;
   localparam logic signed [4:0] GAP_EXTEND_RESET = -5'sd1;
   localparam logic signed [5:0] GAP_OPEN_RESET   = -6'sd5;

   typedef struct packed {
      logic signed [4:0] match_score;
      logic signed [4:0] mismatch_score;
      logic signed [4:0] gap_extend;
      logic signed [5:0] gap_open;
   } agas_cfg_type;

   // one query row travelling along the cells
   typedef struct packed {
      logic                valid;
      logic                first;
      logic                last;
      logic signed [4:0]   ms;
      logic signed [4:0]   mm;
      logic signed [4:0]   ge;
      logic signed [6:0]   goe;
      logic [7:0]          sym;
      logic [CNT_BITS-1:0] cnt;
      agas_score_type      dm;
      agas_score_type      dv;
      agas_score_type      dh;
      agas_score_type      lm;
      agas_score_type      lh;
      agas_score_type      lx;
      agas_score_type      lv;
   } agas_token_type;

   typedef struct packed {
      logic                we;
      logic [IDX_BITS-1:0] index;
      logic [7:0]          sym;
   } agas_load_type;

   function automatic agas_delta_type ext5(input logic signed [4:0] v);
      return {{(DELTA_BITS-5){v[4]}}, v};
   endfunction

   function automatic agas_delta_type ext7(input logic signed [6:0] v);
      return {{(DELTA_BITS-7){v[6]}}, v};
   endfunction

   // minus infinity absorbs, otherwise saturate at both ends
   function automatic agas_score_type sat_add(input agas_score_type s,
                                              input agas_delta_type d);
      logic [SC_BITS+1:0] r;
      agas_score_type     res;
      r = {{2{s[SC_BITS-1]}}, s} + {{(SC_BITS+2-DELTA_BITS){d[DELTA_BITS-1]}}, d};
      if (s == SC_MIN) begin
         res = SC_MIN;
      end else if (r[SC_BITS+1] && !(r[SC_BITS] && r[SC_BITS-1])) begin
         res = SC_MIN;
      end else if (!r[SC_BITS+1] && (r[SC_BITS] || r[SC_BITS-1])) begin
         res = SC_MAX;
      end else begin
         res = r[SC_BITS-1:0];
      end
      return res;
   endfunction

   function automatic agas_score_type max_score(input agas_score_type a,
                                                input agas_score_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

[design/agas_if.sv]
// request and result channel interfaces
interface agas_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] symbol;
   logic       last;

   modport source (output valid, cmd, symbol, last, input ready);
   modport sink (input valid, cmd, symbol, last, output ready);
endinterface

interface agas_rsp_if;
   logic                        valid;
   logic                        ready;
   logic signed [15:0]          best_score;
   logic signed [15:0]          match_end;
   logic signed [15:0]          vgap_end;
   logic signed [15:0]          hgap_end;
   logic                        empty_reference;

   modport source (output valid, best_score, match_end, vgap_end, hgap_end,
                   empty_reference, input ready);
   modport sink (input valid, best_score, match_end, vgap_end, hgap_end,
                 empty_reference, output ready);
endinterface

[design/agas_cell.sv]
// one reference column: stored row scores and one token stage
module agas_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [agas_pkg::CNT_BITS-1:0]  col,
   input  logic                           sym_we,
   input  logic [7:0]                     sym_wdata,
   input  agas_pkg::agas_token_type       left_tok,
   output agas_pkg::agas_token_type       right_tok
);

   logic [7:0]                sym_ff, sym_in;
   agas_pkg::agas_score_type  m_ff, m_in;
   agas_pkg::agas_score_type  v_ff, v_in;
   agas_pkg::agas_score_type  h_ff, h_in;
   agas_pkg::agas_token_type  tok_ff, tok_in;

   logic                      active;
   agas_pkg::agas_delta_type  sub_d, ge_d, goe_d;
   agas_pkg::agas_score_type  up_m, up_v, up_h;
   agas_pkg::agas_score_type  n_m, n_v, n_h, n_x;

   assign active = left_tok.valid && (col < left_tok.cnt);
   assign ge_d   = agas_pkg::ext5(left_tok.ge);
   assign goe_d  = agas_pkg::ext7(left_tok.goe);
   assign sub_d  = (left_tok.sym == sym_ff) ? agas_pkg::ext5(left_tok.ms)
                                            : agas_pkg::ext5(left_tok.mm);

   // first row sees the boundary instead of stored values
   assign up_m = left_tok.first ? agas_pkg::SC_MIN : m_ff;
   assign up_v = left_tok.first ? agas_pkg::SC_MIN : v_ff;
   assign up_h = left_tok.first ? agas_pkg::sat_add(left_tok.dh, ge_d) : h_ff;

   assign n_m = agas_pkg::max_score(
                   agas_pkg::max_score(agas_pkg::sat_add(left_tok.dm, sub_d),
                                       agas_pkg::sat_add(left_tok.dv, sub_d)),
                   agas_pkg::sat_add(left_tok.dh, sub_d));
   assign n_v = agas_pkg::max_score(agas_pkg::sat_add(up_m, goe_d),
                                    agas_pkg::sat_add(up_v, ge_d));
   assign n_h = agas_pkg::max_score(
                   agas_pkg::max_score(agas_pkg::sat_add(left_tok.lm, goe_d),
                                       agas_pkg::sat_add(left_tok.lh, ge_d)),
                   agas_pkg::sat_add(left_tok.lx, ge_d));
   assign n_x = agas_pkg::sat_add(up_v, ge_d);

   always_comb begin
      sym_in = sym_we ? sym_wdata : sym_ff;
      m_in   = m_ff;
      v_in   = v_ff;
      h_in   = h_ff;
      tok_in = tok_ff;
      if (advance) begin
         tok_in = left_tok;
         if (active) begin
            m_in      = n_m;
            v_in      = n_v;
            h_in      = n_h;
            tok_in.dm = up_m;
            tok_in.dv = up_v;
            tok_in.dh = up_h;
            tok_in.lm = n_m;
            tok_in.lh = n_h;
            tok_in.lx = n_x;
            tok_in.lv = n_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      m_ff   <= m_in;
      v_ff   <= v_in;
      h_ff   <= h_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign right_tok = tok_ff;

endmodule

[design/agas_csr.sv]
// configuration registers behind the apb-style port
module agas_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [agas_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [agas_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [agas_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output agas_pkg::agas_cfg_type               cfg
);

   localparam int DW = agas_pkg::CSR_DATA_BITS;

   agas_pkg::agas_cfg_type cfg_ff, cfg_in;
   logic [1:0]             reg_idx;
   logic                   wr_en;

   assign reg_idx = paddr[agas_pkg::CSR_ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            agas_pkg::REG_MATCH:      cfg_in.match_score    = pwdata[4:0];
            agas_pkg::REG_MISMATCH:   cfg_in.mismatch_score = pwdata[4:0];
            agas_pkg::REG_GAP_EXTEND: cfg_in.gap_extend     = pwdata[4:0];
            agas_pkg::REG_GAP_OPEN:   cfg_in.gap_open       = pwdata[5:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_score    <= agas_pkg::MATCH_RESET;
         cfg_ff.mismatch_score <= agas_pkg::MISMATCH_RESET;
         cfg_ff.gap_extend     <= agas_pkg::GAP_EXTEND_RESET;
         cfg_ff.gap_open       <= agas_pkg::GAP_OPEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         agas_pkg::REG_MATCH:      prdata = {{(DW-5){1'b0}}, cfg_ff.match_score};
         agas_pkg::REG_MISMATCH:   prdata = {{(DW-5){1'b0}}, cfg_ff.mismatch_score};
         agas_pkg::REG_GAP_EXTEND: prdata = {{(DW-5){1'b0}}, cfg_ff.gap_extend};
         agas_pkg::REG_GAP_OPEN:   prdata = {{(DW-6){1'b0}}, cfg_ff.gap_open};
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[design/agas_head.sv]
// request intake: reference loads, row start values and token injection
module agas_head (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  agas_pkg::agas_cfg_type    cfg,
   input  logic                      req_valid,
   input  logic                      cmd,
   input  logic [7:0]                symbol,
   input  logic                      last,
   output agas_pkg::agas_token_type  head_tok,
   output agas_pkg::agas_load_type   load
);

   localparam int CW = agas_pkg::CNT_BITS;
   localparam int SW = agas_pkg::SC_BITS;

   logic [CW-1:0]             count_ff, count_in;
   logic                      closed_ff, closed_in;
   logic                      first_row_ff, first_row_in;
   agas_pkg::agas_score_type  left_vgap_ff, left_vgap_in;
   agas_pkg::agas_token_type  tok_ff, tok_in;

   logic                      accept;
   logic                      has_room;
   agas_pkg::agas_score_type  go_s, lv_base, lv_new;

   assign accept   = req_valid && advance;
   assign has_room = count_ff < CW'(agas_pkg::MAX_REF_LEN);
   assign go_s     = {{(SW-6){cfg.gap_open[5]}}, cfg.gap_open};
   assign lv_base  = first_row_ff ? go_s : left_vgap_ff;
   assign lv_new   = agas_pkg::sat_add(lv_base, agas_pkg::ext5(cfg.gap_extend));

   always_comb begin
      count_in     = count_ff;
      closed_in    = closed_ff;
      first_row_in = first_row_ff;
      left_vgap_in = left_vgap_ff;
      tok_in       = tok_ff;
      load         = '0;
      load.sym     = symbol;
      if (advance) begin
         tok_in = '0;
      end
      if (accept) begin
         if (cmd == agas_pkg::CMD_LOAD) begin
            // a closed reference restarts at column zero
            if (closed_ff) begin
               load.we    = 1'b1;
               load.index = '0;
               count_in   = CW'(1);
            end else if (has_room) begin
               load.we    = 1'b1;
               load.index = count_ff[agas_pkg::IDX_BITS-1:0];
               count_in   = count_ff + CW'(1);
            end
            closed_in    = last;
            first_row_in = 1'b1;
         end else begin
            tok_in.valid = 1'b1;
            tok_in.first = first_row_ff;
            tok_in.last  = last;
            tok_in.ms    = cfg.match_score;
            tok_in.mm    = cfg.mismatch_score;
            tok_in.ge    = cfg.gap_extend;
            tok_in.goe   = {cfg.gap_open[5], cfg.gap_open}
                           + {{2{cfg.gap_extend[4]}}, cfg.gap_extend};
            tok_in.sym   = symbol;
            tok_in.cnt   = count_ff;
            tok_in.dm    = first_row_ff ? '0 : agas_pkg::SC_MIN;
            tok_in.dv    = first_row_ff ? go_s : left_vgap_ff;
            tok_in.dh    = first_row_ff ? go_s : agas_pkg::SC_MIN;
            tok_in.lm    = agas_pkg::SC_MIN;
            tok_in.lh    = agas_pkg::SC_MIN;
            tok_in.lx    = agas_pkg::SC_MIN;
            tok_in.lv    = lv_new;
            left_vgap_in = lv_new;
            first_row_in = last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         first_row_ff <= 1'b1;
         left_vgap_ff <= {{(SW-6){agas_pkg::GAP_OPEN_RESET[5]}}, agas_pkg::GAP_OPEN_RESET};
         tok_ff       <= '0;
      end else begin
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         first_row_ff <= first_row_in;
         left_vgap_ff <= left_vgap_in;
         tok_ff       <= tok_in;
      end
   end

   assign head_tok = tok_ff;

endmodule

[design/affine_gap_alignment_score.sv]
// affine gap global alignment score: systolic row of reference columns
//
//   channel   direction  contents
//   req_chan  in         cmd, symbol, last
//   rsp_chan  out        best_score, match_end, vgap_end, hgap_end, empty_reference
//   apb       in/out     match_score, mismatch_score, gap_extend, gap_open
//
// one request is taken per cycle unless the row stalls; a query row walks one column
// per cycle down MAX_REF_LEN cells while it advances, and its result is registered in
// the head stage, then one stage per cell, then the output register before it shows.
// synchronous reset clears control only; no clearing pass is needed.
// the row stalls only when a result reaches the tail while the output
// register still holds an untaken result.
module affine_gap_alignment_score (
   input  logic                                clock,
   input  logic                                reset,
   agas_req_if.sink                            req_chan,
   agas_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [agas_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [agas_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [agas_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);

   localparam int CW  = agas_pkg::CNT_BITS;
   localparam int IW  = agas_pkg::IDX_BITS;
   localparam int LEN = agas_pkg::MAX_REF_LEN;

   agas_pkg::agas_cfg_type    cfg;
   agas_pkg::agas_load_type   load;
   agas_pkg::agas_token_type  tok_chain [0:LEN];
   agas_pkg::agas_token_type  tail;

   logic                      advance;
   logic                      emit;
   logic                      empty_ref;
   agas_pkg::agas_score_type  best;

   logic                      rsp_valid_ff, rsp_valid_in;
   agas_pkg::agas_score_type  best_ff, best_in;
   agas_pkg::agas_score_type  match_ff, match_in;
   agas_pkg::agas_score_type  vgap_ff, vgap_in;
   agas_pkg::agas_score_type  hgap_ff, hgap_in;
   logic                      empty_ff, empty_in;

   agas_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   agas_head u_head (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg),
      .req_valid (req_chan.valid),
      .cmd       (req_chan.cmd),
      .symbol    (req_chan.symbol),
      .last      (req_chan.last),
      .head_tok  (tok_chain[0]),
      .load      (load)
   );

   for (genvar j = 0; j < LEN; j++) begin : g_cell
      agas_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .col       (CW'(j)),
         .sym_we    (load.we && (load.index == IW'(j))),
         .sym_wdata (load.sym),
         .left_tok  (tok_chain[j]),
         .right_tok (tok_chain[j+1])
      );
   end

   assign tail      = tok_chain[LEN];
   assign emit      = tail.valid && tail.last;
   assign advance   = !(rsp_valid_ff && !rsp_chan.ready && emit);
   assign empty_ref = (tail.cnt == '0);
   assign best      = empty_ref ? agas_pkg::SC_MIN
                    : agas_pkg::max_score(agas_pkg::max_score(tail.lm, tail.lv), tail.lh);

   assign req_chan.ready = advance;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      best_in      = best_ff;
      match_in     = match_ff;
      vgap_in      = vgap_ff;
      hgap_in      = hgap_ff;
      empty_in     = empty_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         best_in      = best;
         match_in     = tail.lm;
         vgap_in      = tail.lv;
         hgap_in      = tail.lh;
         empty_in     = empty_ref;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff  <= best_in;
      match_ff <= match_in;
      vgap_ff  <= vgap_in;
      hgap_ff  <= hgap_in;
      empty_ff <= empty_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.best_score      = best_ff;
   assign rsp_chan.match_end       = match_ff;
   assign rsp_chan.vgap_end        = vgap_ff;
   assign rsp_chan.hgap_end        = hgap_ff;
   assign rsp_chan.empty_reference = empty_ff;

endmodule

[design/agas_checker.sv]
// port-level checks of the alignment score block, bound to the top level
`include "affine_gap_alignment_score_assert.svh"

module agas_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic signed [15:0]  best_score,
   input logic signed [15:0]  match_end,
   input logic signed [15:0]  vgap_end,
   input logic signed [15:0]  hgap_end,
   input logic                empty_reference
);

   `AGAS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `AGAS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(best_score) && $stable(match_end) && $stable(vgap_end) && $stable(hgap_end) && $stable(empty_reference))
   `AGAS_ASSERT_NOW(a_empty_scores, rsp_valid && empty_reference, best_score == agas_pkg::SC_MIN && match_end == agas_pkg::SC_MIN && hgap_end == agas_pkg::SC_MIN)
   `AGAS_ASSERT_NOW(a_best_is_max, rsp_valid && !empty_reference, best_score >= match_end && best_score >= vgap_end && best_score >= hgap_end)
   `AGAS_ASSERT_ALWAYS_NEXT(a_reset_quiet, reset, !rsp_valid)

endmodule

bind affine_gap_alignment_score agas_checker u_agas_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .best_score      (rsp_chan.best_score),
   .match_end       (rsp_chan.match_end),
   .vgap_end        (rsp_chan.vgap_end),
   .hgap_end        (rsp_chan.hgap_end),
   .empty_reference (rsp_chan.empty_reference)
);
